FILE: design/aesctr_pkg.sv
`default_nettype none
package aesctr_pkg;

   localparam int unsigned NumRounds = 10;

   typedef logic [127:0] block_type;

   // forward s-box as a constant table
   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] tab [256];
      tab = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return tab[x];
   endfunction

   // round constant for round r (0 based)
   function automatic logic [7:0] rcon(input logic [3:0] r);
      logic [7:0] v;
      unique case (r)
         4'd0: v = 8'h01;
         4'd1: v = 8'h02;
         4'd2: v = 8'h04;
         4'd3: v = 8'h08;
         4'd4: v = 8'h10;
         4'd5: v = 8'h20;
         4'd6: v = 8'h40;
         4'd7: v = 8'h80;
         4'd8: v = 8'h1b;
         4'd9: v = 8'h36;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of a block, byte 0 in the top bits
   function automatic logic [7:0] get_byte(input block_type b, input int unsigned i);
      return b[127 - 8*i -: 8];
   endfunction

endpackage
`default_nettype wire

FILE: design/aesctr_if.sv
`default_nettype none
interface aesctr_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] key_high;
   logic [63:0] key_low;
   logic [63:0] block_index;
   modport source (output valid, key_high, key_low, block_index, input ready);
   modport sink (input valid, key_high, key_low, block_index, output ready);
endinterface

interface aesctr_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] block_high;
   logic [63:0] block_low;
   modport source (output valid, block_high, block_low, input ready);
   modport sink (input valid, block_high, block_low, output ready);
endinterface
`default_nettype wire

FILE: design/aesctr_round.sv
`default_nettype none
// one registered aes round with its key expansion step
module aesctr_round
   import aesctr_pkg::*;
#(
   parameter logic [3:0] ROUND = 4'd0
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      advance,
   input  wire logic      valid_in,
   input  wire block_type state_in,
   input  wire block_type key_in,
   output logic           valid_ff,
   output block_type      state_ff,
   output block_type      key_ff
);

   block_type key_in_c;
   block_type sub_c;
   block_type mix_c;
   logic [7:0] t [4];

   // next round key
   always_comb begin
      t[0] = sbox(get_byte(key_in, 13)) ^ rcon(ROUND);
      t[1] = sbox(get_byte(key_in, 14));
      t[2] = sbox(get_byte(key_in, 15));
      t[3] = sbox(get_byte(key_in, 12));
      for (int i = 0; i < 4; i++) begin
         key_in_c[127-8*i -: 8] = get_byte(key_in, i) ^ t[i];
      end
      for (int i = 4; i < 16; i++) begin
         key_in_c[127-8*i -: 8] = get_byte(key_in, i) ^ key_in_c[127-8*(i-4) -: 8];
      end
   end

   // subbytes and shiftrows
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            sub_c[127-8*(r+4*c) -: 8] = sbox(get_byte(state_in, r + 4*((c + r) % 4)));
         end
      end
   end

   // mixcolumns, skipped in the last round
   always_comb begin
      logic [7:0] a0, a1, a2, a3, all;
      mix_c = sub_c;
      if (ROUND < 4'(NumRounds - 1)) begin
         for (int c = 0; c < 4; c++) begin
            a0 = get_byte(sub_c, 4*c);
            a1 = get_byte(sub_c, 4*c+1);
            a2 = get_byte(sub_c, 4*c+2);
            a3 = get_byte(sub_c, 4*c+3);
            all = a0 ^ a1 ^ a2 ^ a3;
            mix_c[127-8*(4*c)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
            mix_c[127-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
            mix_c[127-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            mix_c[127-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
         end
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         state_ff <= mix_c ^ key_in_c;
         key_ff   <= key_in_c;
      end
   end

endmodule
`default_nettype wire

FILE: design/aes128_ctr_keystream.sv
// an accepted item passes the key-add register and then one register per round before its result is offered
// throughput: one item per cycle while the output is not stalled, one aes round per pipeline stage
// the whole pipeline advances together, held while the output is stalled
// reset (synchronous, active high) clears all valid bits; data is not cleared
`default_nettype none
module aes128_ctr_keystream
   import aesctr_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   aesctr_req_if.sink   req,
   aesctr_rsp_if.source rsp
);

   logic      advance;
   logic      v    [NumRounds+1];
   block_type st   [NumRounds+1];
   block_type ky   [NumRounds+1];

   // a stage moves when the output is free or the last stage is empty
   assign advance   = rsp.ready || !v[NumRounds];
   assign req.ready = advance;

   // initial add of the key to the counter block
   logic      v0_ff;
   block_type s0_ff;
   block_type k0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (advance) begin
         v0_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_ff <= {64'd0, req.block_index} ^ {req.key_high, req.key_low};
         k0_ff <= {req.key_high, req.key_low};
      end
   end

   assign v[0]  = v0_ff;
   assign st[0] = s0_ff;
   assign ky[0] = k0_ff;

   // ten round stages
   for (genvar g = 0; g < NumRounds; g++) begin : g_round
      aesctr_round #(.ROUND(4'(g))) u_round (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .valid_in (v[g]),
         .state_in (st[g]),
         .key_in   (ky[g]),
         .valid_ff (v[g+1]),
         .state_ff (st[g+1]),
         .key_ff   (ky[g+1])
      );
   end

   assign rsp.valid      = v[NumRounds];
   assign rsp.block_high = st[NumRounds][127:64];
   assign rsp.block_low  = st[NumRounds][63:0];

   // a stalled result stays valid and keeps its high half
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.block_high))
      else $error("stalled result changed");

   // input is refused only when a result waits
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> rsp.valid && !rsp.ready)
      else $error("ready dropped without stall");

   // first stage valid follows an accepted item
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> v0_ff)
      else $error("accepted item lost");

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
`default_nettype none
module tb_top
   import aesctr_pkg::*;
();

   localparam int unsigned Latency = 11;
   localparam longint unsigned CycleLimit = 400000;
   localparam int unsigned HoldLength = 60;

   typedef struct packed {
      logic [63:0] key_high;
      logic [63:0] key_low;
      logic [63:0] block_index;
   } ctr_item_type;

   typedef struct packed {
      logic [63:0] block_high;
      logic [63:0] block_low;
   } keystream_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   aesctr_req_if req_ch ();
   aesctr_rsp_if rsp_ch ();

   aes128_ctr_keystream u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   always #1 clock = ~clock;

   // idling percentages, changed per phase
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   bit          hold_rsp = 1'b0;
   int unsigned hold_cycles = 0;

   keystream_type expected_blocks[$];
   int unsigned fail_count = 0;
   int unsigned items_sent = 0;
   int unsigned blocks_checked = 0;
   longint unsigned cycle_count = 0;

   // expand key on the fly and encrypt the counter block
   function automatic keystream_type aes_encrypt_counter(input ctr_item_type it);
      logic [7:0] rk [16];
      logic [7:0] st [16];
      logic [7:0] tmp [16];
      logic [7:0] t0, t1, t2, t3, a0, a1, a2, a3, all_x;
      logic [7:0] rc;
      keystream_type res;
      for (int i = 0; i < 8; i++) begin
         rk[i] = it.key_high[63 - 8*i -: 8];
         rk[i+8] = it.key_low[63 - 8*i -: 8];
         st[i] = 8'h00;
         st[i+8] = it.block_index[63 - 8*i -: 8];
      end
      for (int i = 0; i < 16; i++) st[i] ^= rk[i];
      rc = 8'h01;
      for (int r = 0; r < NumRounds; r++) begin
         // next round key
         t0 = sbox(rk[13]) ^ rc;
         t1 = sbox(rk[14]);
         t2 = sbox(rk[15]);
         t3 = sbox(rk[12]);
         rk[0] ^= t0; rk[1] ^= t1; rk[2] ^= t2; rk[3] ^= t3;
         for (int i = 4; i < 16; i++) rk[i] ^= rk[i-4];
         rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
         // sub bytes and shift rows
         for (int c = 0; c < 4; c++)
            for (int w = 0; w < 4; w++)
               tmp[w + 4*c] = sbox(st[w + 4*((c + w) % 4)]);
         st = tmp;
         // mix columns, skipped in the last round
         if (r < NumRounds - 1) begin
            for (int c = 0; c < 4; c++) begin
               a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
               all_x = a0 ^ a1 ^ a2 ^ a3;
               st[4*c]   = a0 ^ all_x ^ xtime(a0 ^ a1);
               st[4*c+1] = a1 ^ all_x ^ xtime(a1 ^ a2);
               st[4*c+2] = a2 ^ all_x ^ xtime(a2 ^ a3);
               st[4*c+3] = a3 ^ all_x ^ xtime(a3 ^ a0);
            end
         end
         for (int i = 0; i < 16; i++) st[i] ^= rk[i];
      end
      for (int i = 0; i < 8; i++) begin
         res.block_high[63 - 8*i -: 8] = st[i];
         res.block_low[63 - 8*i -: 8] = st[i+8];
      end
      return res;
   endfunction

   // send one item, with random idle cycles first; valid stays up after acceptance
   task automatic send_item(input ctr_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.key_high <= it.key_high;
      req_ch.key_low <= it.key_low;
      req_ch.block_index <= it.block_index;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_blocks.push_back(aes_encrypt_counter(it));
      items_sent++;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic ctr_item_type rand_item();
      ctr_item_type it;
      it.key_high = rand64();
      it.key_low = rand64();
      it.block_index = rand64();
      return it;
   endfunction

   // stop offering items and wait for every result
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (expected_blocks.size() != 0) @(posedge clock);
   endtask

   // receiver ready, with random stalls and one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_rsp && hold_cycles < HoldLength) begin
         rsp_ch.ready <= 1'b0;
         hold_cycles <= hold_cycles + 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // compare each keystream block with the oldest expectation
   always @(posedge clock) begin
      keystream_type exp_blk;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_blocks.size() == 0) begin
            $error("unexpected keystream block %h %h", rsp_ch.block_high, rsp_ch.block_low);
            fail_count++;
         end else begin
            exp_blk = expected_blocks.pop_front();
            if (rsp_ch.block_high !== exp_blk.block_high) begin
               $error("block_high expected %h actual %h", exp_blk.block_high,
                      rsp_ch.block_high);
               fail_count++;
            end
            if (rsp_ch.block_low !== exp_blk.block_low) begin
               $error("block_low expected %h actual %h", exp_blk.block_low,
                      rsp_ch.block_low);
               fail_count++;
            end
            blocks_checked++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("aes128_ctr_keystream test failed");
         $finish;
      end
   end

   // known vector and field extremes
   task automatic test_directed();
      ctr_item_type it;
      // standard test key with index 0 to 3, as in a ctr stream
      it.key_high = 64'h2b7e151628aed2a6;
      it.key_low = 64'habf7158809cf4f3c;
      for (int i = 0; i < 4; i++) begin
         it.block_index = 64'(i);
         send_item(it);
      end
      for (int k = 0; k < 8; k++) begin
         it.key_high = k[0] ? '1 : '0;
         it.key_low = k[1] ? '1 : '0;
         it.block_index = k[2] ? '1 : '0;
         send_item(it);
      end
      // walking ones across every field
      for (int b = 0; b < 64; b += 9) begin
         it.key_high = 64'd1 << b;
         it.key_low = 64'd1 << (63 - b);
         it.block_index = 64'd1 << b;
         send_item(it);
      end
   endtask

   // consecutive indices from a random start, now and then a new random key and start
   task automatic test_stream(input int unsigned n);
      ctr_item_type it;
      it = rand_item();
      for (int unsigned i = 0; i < n; i++) begin
         if ($urandom_range(15) == 0) it = rand_item();
         else it.block_index = it.block_index + 1;
         send_item(it);
      end
   endtask

   task automatic test_random(input int unsigned n);
      for (int unsigned i = 0; i < n; i++) send_item(rand_item());
   endtask

   // stall the output long enough to fill the pipeline
   task automatic test_backpressure();
      hold_rsp = 1'b1;
      test_random(40);
      wait_drained();
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.key_high = '0;
      req_ch.key_low = '0;
      req_ch.block_index = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      wait_drained();
      send_idle_pct = 19; recv_idle_pct = 47;
      test_stream(150);
      test_random(150);
      send_idle_pct = 47; recv_idle_pct = 19;
      test_stream(150);
      test_random(150);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_backpressure();
      test_stream(150);
      test_random(130);
      wait_drained();
      repeat (Latency + 5) @(posedge clock);
      $display("sent %0d items (counter streams, random keys, extremes), checked %0d blocks",
               items_sent, blocks_checked);
      $display("covered sender and receiver idling and a long output stall");
      if (fail_count == 0 && expected_blocks.size() == 0) begin
         $display("aes128_ctr_keystream test passed");
      end else begin
         $display("aes128_ctr_keystream test failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

FILE: sim.f
design/aesctr_pkg.sv
design/aesctr_if.sv
design/aesctr_round.sv
design/aes128_ctr_keystream.sv
tb/sv/tb_top.sv
